// ----- rtl/touch_key_decode_debounce_macros.svh -----
// Assertion macros for the touch key decoder.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef TOUCH_KEY_DECODE_DEBOUNCE_MACROS_SVH
`define TOUCH_KEY_DECODE_DEBOUNCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TKD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch key decoder check failed");

// Next-cycle implication, disabled while reset is asserted
`define TKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch key decoder check failed");

`endif

// ----- rtl/tkd_pkg.sv -----
// Shared types, constants and key-window decode for the touch key decoder.
// No dependencies.
package tkd_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned OHMS_W   = 10;
    localparam int unsigned TICKS_W  = 5;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned NUM_KEYS = 6;
    localparam int unsigned LONG_W   = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    // Product widths of the serial multipliers
    localparam int unsigned PROD_W = OHMS_W + CODE_W;      // plate*x, limit*z1
    localparam int unsigned LHS_W  = PROD_W + CODE_W;      // plate*x*(z2-z1)
    localparam int unsigned FS_SHIFT = 12;                 // times 4096
    localparam int unsigned CMP_W  = PROD_W + FS_SHIFT;

    // Register reset values
    localparam logic [OHMS_W-1:0]  PLATE_RST = 10'd270;
    localparam logic [OHMS_W-1:0]  LIMIT_RST = 10'd40;
    localparam logic [TICKS_W-1:0] MIN_RST   = 5'd3;
    localparam logic [TICKS_W-1:0] LONG_RST  = 5'd24;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLATE = 2'd0,
        CFG_LIMIT = 2'd1,
        CFG_MIN   = 2'd2,
        CFG_LONG  = 2'd3
    } t_cfg_idx;

    // Key windows (upper 8 bits of the samples)
    localparam logic [CODE_W-1:0] Y_LO_MIN = 8'h20;
    localparam logic [CODE_W-1:0] Y_LO_MAX = 8'h38;
    localparam logic [CODE_W-1:0] Y_HI_MIN = 8'h40;
    localparam logic [CODE_W-1:0] Y_HI_MAX = 8'h59;
    localparam logic [CODE_W-1:0] X_C0_MIN = 8'h40;
    localparam logic [CODE_W-1:0] X_C0_MAX = 8'h5F;
    localparam logic [CODE_W-1:0] X_C1_MIN = 8'h70;
    localparam logic [CODE_W-1:0] X_C1_MAX = 8'h90;
    localparam logic [CODE_W-1:0] X_C2_MIN = 8'hA2;
    localparam logic [CODE_W-1:0] X_C2_MAX = 8'hC0;

    // Keys that can flag a long hold
    localparam int unsigned KEY_DN = 3;
    localparam int unsigned KEY_UP = 4;

    // One-hot key selected by the X/Y windows, zero outside every window
    function automatic logic [NUM_KEYS-1:0] key_of(input logic [CODE_W-1:0] x,
                                                    input logic [CODE_W-1:0] y);
        logic c0, c1, c2, lo, hi;
        logic [NUM_KEYS-1:0] k;
        c0 = (x >= X_C0_MIN) && (x <= X_C0_MAX);
        c1 = (x >= X_C1_MIN) && (x <= X_C1_MAX);
        c2 = (x >= X_C2_MIN) && (x <= X_C2_MAX);
        lo = (y >= Y_LO_MIN) && (y <= Y_LO_MAX);
        hi = (y >= Y_HI_MIN) && (y <= Y_HI_MAX);
        k  = '0;
        if (lo) begin
            k[0] = c0;
            k[5] = c1;
            k[3] = c2;
        end else if (hi) begin
            k[1] = c0;
            k[2] = c1;
            k[4] = c2;
        end
        return k;
    endfunction

endpackage

// ----- rtl/touch_key_decode_debounce.sv -----
// Touch panel key decoder: bit-serial contact test, key windows and debounce.
// Depends on tkd_pkg and touch_key_decode_debounce_macros.svh.
//
// Usage: one input item per converter tick carries raw X, Y, Z1 and Z2
// samples on i_in_valid / o_in_stall; one result item (contact, held keys,
// short-press pulses, long-hold flags) leaves on o_out_valid / i_out_stall.
// The result register is loaded after the serial plate*x and limit*z1 step,
// the serial (plate*x)*(z2-z1) step and the key update. A new item is not
// taken until the previous one has left S_DONE; the two bit-serial
// shift-add multipliers set the pace of items.
// o_in_stall is high while an item is at work; a new item may be taken
// while the previous result still waits in the output register. If the
// receiver stalls, the finished item waits before updating key state until
// the output register is free.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at
// once. The user must make them while the block is idle; the block does not enforce this.
// Reset (synchronous, active low) restores register defaults, releases all
// keys, clears counters and flags and empties the output register.
`include "touch_key_decode_debounce_macros.svh"

module touch_key_decode_debounce (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [tkd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tkd_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [tkd_pkg::SAMPLE_W-1:0]          i_x_sample,
    input  logic [tkd_pkg::SAMPLE_W-1:0]          i_y_sample,
    input  logic [tkd_pkg::SAMPLE_W-1:0]          i_z1_sample,
    input  logic [tkd_pkg::SAMPLE_W-1:0]          i_z2_sample,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_contact,
    output logic [tkd_pkg::NUM_KEYS-1:0]          o_held_mask,
    output logic [tkd_pkg::NUM_KEYS-1:0]          o_short_press_mask,
    output logic [tkd_pkg::LONG_W-1:0]            o_long_hold_mask
);
    import tkd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_DONE
    } t_state;

    localparam int unsigned BIT_CNT_W = $clog2(CODE_W);

    // Configuration registers
    logic [OHMS_W-1:0]  r_plate;
    logic [OHMS_W-1:0]  r_limit;
    logic [TICKS_W-1:0] r_min;
    logic [TICKS_W-1:0] r_long;

    // Control
    t_state               r_state;
    logic [BIT_CNT_W-1:0] r_bit_cnt;

    // Item data and serial datapath
    logic [CODE_W-1:0] r_x;
    logic [CODE_W-1:0] r_y;
    logic [CODE_W-1:0] r_xs;       // x bits, MSB first
    logic [CODE_W-1:0] r_z1s;      // z1 bits, MSB first
    logic [CODE_W-1:0] r_ds;       // z2-z1 bits, MSB first
    logic              r_z1_nz;
    logic              r_d_pos;    // z2 > z1
    logic [PROD_W-1:0] r_p;        // plate * x
    logic [PROD_W-1:0] r_q;        // limit * z1
    logic [LHS_W-1:0]  r_lhs;      // plate * x * (z2 - z1)

    // Key state
    logic [NUM_KEYS-1:0] r_held;
    logic [COUNT_W-1:0]  r_cnt  [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_flag;

    // Output register
    logic                r_out_valid;
    logic                r_contact;
    logic [NUM_KEYS-1:0] r_held_o;
    logic [NUM_KEYS-1:0] r_short_o;
    logic [LONG_W-1:0]   r_long_o;

    // Next key state
    logic                n_contact;
    logic [NUM_KEYS-1:0] n_held;
    logic [COUNT_W-1:0]  n_cnt  [NUM_KEYS];
    logic [NUM_KEYS-1:0] n_flag;
    logic [NUM_KEYS-1:0] n_short;

    logic              in_acc;
    logic              out_free;
    logic [CODE_W-1:0] x_code;
    logic [CODE_W-1:0] z1_code;
    logic [CODE_W-1:0] z2_code;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign x_code   = i_x_sample[SAMPLE_W-1 -: CODE_W];
    assign z1_code  = i_z1_sample[SAMPLE_W-1 -: CODE_W];
    assign z2_code  = i_z2_sample[SAMPLE_W-1 -: CODE_W];

    // Contact decision, key map and per-key debounce
    always_comb begin
        logic too_high;
        too_high  = {{(CMP_W-LHS_W){1'b0}}, r_lhs} > {r_q, {FS_SHIFT{1'b0}}};
        n_contact = r_z1_nz && !(r_d_pos && too_high);
        n_held    = n_contact ? (r_held | key_of(r_x, r_y)) : '0;
        n_flag    = r_flag;
        n_short   = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_cnt[k] = r_cnt[k];
            if (n_held[k]) begin
                if (!r_held[k]) begin
                    n_cnt[k] = COUNT_W'(1);
                end else if (r_cnt[k] > {{(COUNT_W-TICKS_W){1'b0}}, r_long}) begin
                    if (k == KEY_DN || k == KEY_UP) begin
                        n_flag[k] = 1'b1;
                    end
                end else begin
                    n_cnt[k] = r_cnt[k] + COUNT_W'(1);
                end
            end else if (r_held[k] &&
                         (r_cnt[k] > {{(COUNT_W-TICKS_W){1'b0}}, r_min})) begin
                if (r_flag[k]) begin
                    n_flag[k] = 1'b0;
                end else begin
                    n_short[k] = 1'b1;
                end
                n_cnt[k] = '0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plate <= PLATE_RST;
            r_limit <= LIMIT_RST;
            r_min   <= MIN_RST;
            r_long  <= LONG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLATE: r_plate <= i_cfg_wdata[OHMS_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_wdata[OHMS_W-1:0];
                CFG_MIN:   r_min   <= i_cfg_wdata[TICKS_W-1:0];
                CFG_LONG:  r_long  <= i_cfg_wdata[TICKS_W-1:0];
            endcase
        end
    end

    // Sequencer, serial multipliers, key state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit_cnt   <= '0;
            r_held      <= '0;
            r_flag      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            // result leaves; a result stored in S_DONE refills the register
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x       <= x_code;
                        r_y       <= i_y_sample[SAMPLE_W-1 -: CODE_W];
                        r_xs      <= x_code;
                        r_z1s     <= z1_code;
                        r_ds      <= z2_code - z1_code;
                        r_z1_nz   <= (z1_code != '0);
                        r_d_pos   <= (z2_code > z1_code);
                        r_p       <= '0;
                        r_q       <= '0;
                        r_lhs     <= '0;
                        r_bit_cnt <= '0;
                        r_state   <= S_MUL_A;
                    end
                end
                S_MUL_A: begin
                    // plate*x and limit*z1, one multiplier bit a cycle
                    r_p   <= {r_p[PROD_W-2:0], 1'b0}
                             + (r_xs[CODE_W-1] ? PROD_W'(r_plate) : '0);
                    r_q   <= {r_q[PROD_W-2:0], 1'b0}
                             + (r_z1s[CODE_W-1] ? PROD_W'(r_limit) : '0);
                    r_xs  <= {r_xs[CODE_W-2:0], 1'b0};
                    r_z1s <= {r_z1s[CODE_W-2:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
                    if (r_bit_cnt == BIT_CNT_W'(CODE_W-1)) begin
                        r_state <= S_MUL_B;
                    end
                end
                S_MUL_B: begin
                    // (plate*x) * (z2-z1), one bit a cycle
                    r_lhs <= {r_lhs[LHS_W-2:0], 1'b0}
                             + (r_ds[CODE_W-1] ? LHS_W'(r_p) : '0);
                    r_ds  <= {r_ds[CODE_W-2:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
                    if (r_bit_cnt == BIT_CNT_W'(CODE_W-1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // commit key state only when the result can be stored
                    if (out_free) begin
                        r_held      <= n_held;
                        r_flag      <= n_flag;
                        for (int k = 0; k < NUM_KEYS; k++) begin
                            r_cnt[k] <= n_cnt[k];
                        end
                        r_out_valid <= 1'b1;
                        r_contact   <= n_contact;
                        r_held_o    <= n_held;
                        r_short_o   <= n_short;
                        r_long_o    <= {n_flag[KEY_UP], n_flag[KEY_DN]};
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_contact          = r_contact;
    assign o_held_mask        = r_held_o;
    assign o_short_press_mask = r_short_o;
    assign o_long_hold_mask   = r_long_o;

    // Checks
    `TKD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == S_MUL_A)
    `TKD_ASSERT_SAME(a_load_from_done, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == S_DONE))
    `TKD_ASSERT_SAME(a_no_contact_release, i_clk, i_rst_n, o_out_valid && !o_contact, o_held_mask == '0)
    `TKD_ASSERT_SAME(a_short_not_held, i_clk, i_rst_n, o_out_valid, (o_short_press_mask & o_held_mask) == '0)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for touch_key_decode_debounce: drives raw touch samples,
// predicts contact, held keys, short-press pulses and long-hold flags per item.
// Depends on tkd_pkg and the RTL top level only.

module tb_top;
    import tkd_pkg::*;

    localparam int LATENCY = 17;
    localparam int PHASE_ITEMS = 85;

    // One expected or observed result item
    typedef struct packed {
        logic                contact;
        logic [NUM_KEYS-1:0] held;
        logic [NUM_KEYS-1:0] shorts;
        logic [LONG_W-1:0]   longs;
    } t_key_report;

    // Key decoder mirror plus queue of predicted reports
    class key_scoreboard;
        logic [OHMS_W-1:0]   plate;
        logic [OHMS_W-1:0]   limit;
        logic [TICKS_W-1:0]  min_ticks;
        logic [TICKS_W-1:0]  long_ticks;
        logic [NUM_KEYS-1:0] held_now;
        logic [NUM_KEYS-1:0] held_prev;
        logic [COUNT_W-1:0]  press_cnt [NUM_KEYS];
        logic                long_flag [NUM_KEYS];
        t_key_report         expected_q [$];
        int                  errors;

        function new();
            plate      = PLATE_RST;
            limit      = LIMIT_RST;
            min_ticks  = MIN_RST;
            long_ticks = LONG_RST;
            held_now   = '0;
            held_prev  = '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                press_cnt[k] = '0;
                long_flag[k] = 1'b0;
            end
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_PLATE: plate      = v[OHMS_W-1:0];
                CFG_LIMIT: limit      = v[OHMS_W-1:0];
                CFG_MIN:   min_ticks  = v[TICKS_W-1:0];
                CFG_LONG:  long_ticks = v[TICKS_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the report caused by one accepted sample set
        function void note_sample(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
                                  logic [SAMPLE_W-1:0] z1s, logic [SAMPLE_W-1:0] z2s);
            logic [CODE_W-1:0] xc, yc, z1c, z2c;
            longint lhs, rhs;
            int col;
            int lower_key [3] = '{0, 5, 3};
            int upper_key [3] = '{1, 2, 4};
            t_key_report rep;
            xc  = xs[SAMPLE_W-1 -: CODE_W];
            yc  = ys[SAMPLE_W-1 -: CODE_W];
            z1c = z1s[SAMPLE_W-1 -: CODE_W];
            z2c = z2s[SAMPLE_W-1 -: CODE_W];
            rep = '0;

            // resistance test in integer form
            if (z1c == '0) begin
                rep.contact = 1'b0;
            end else begin
                lhs = longint'(plate) * longint'(xc) * (longint'(z2c) - longint'(z1c));
                rhs = longint'(limit) * (longint'(1) << FS_SHIFT) * longint'(z1c);
                rep.contact = !(lhs > rhs);
            end

            // key windows; held bits only accumulate while touched
            if (!rep.contact) begin
                held_now = '0;
            end else begin
                if (xc >= X_C0_MIN && xc <= X_C0_MAX)      col = 0;
                else if (xc >= X_C1_MIN && xc <= X_C1_MAX) col = 1;
                else if (xc >= X_C2_MIN && xc <= X_C2_MAX) col = 2;
                else                                       col = 3;
                if (col < 3) begin
                    if (yc >= Y_LO_MIN && yc <= Y_LO_MAX)
                        held_now[lower_key[col]] = 1'b1;
                    else if (yc >= Y_HI_MIN && yc <= Y_HI_MAX)
                        held_now[upper_key[col]] = 1'b1;
                end
            end

            // per-key counters, long flags and release pulses
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (held_now[k]) begin
                    if (!held_prev[k]) begin
                        press_cnt[k] = COUNT_W'(1);
                    end else if (press_cnt[k] > long_ticks) begin
                        if (k == KEY_DN || k == KEY_UP) long_flag[k] = 1'b1;
                    end else begin
                        press_cnt[k] = press_cnt[k] + 1'b1;
                    end
                end else if (held_prev[k] && press_cnt[k] > min_ticks) begin
                    if (long_flag[k]) long_flag[k] = 1'b0;
                    else rep.shorts[k] = 1'b1;
                    press_cnt[k] = '0;
                end
            end
            held_prev  = held_now;
            rep.held   = held_now;
            rep.longs  = {long_flag[KEY_UP], long_flag[KEY_DN]};
            expected_q.push_back(rep);
        endfunction

        function void check_report(t_key_report got);
            t_key_report exp_rep;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected report, nothing pending: actual %h", $realtime, got);
                errors++;
                return;
            end
            exp_rep = expected_q.pop_front();
            if (got.contact !== exp_rep.contact) begin
                $display("%0t: contact expected %b actual %b",
                         $realtime, exp_rep.contact, got.contact);
                errors++;
            end
            if (got.held !== exp_rep.held) begin
                $display("%0t: held_mask expected %b actual %b",
                         $realtime, exp_rep.held, got.held);
                errors++;
            end
            if (got.shorts !== exp_rep.shorts) begin
                $display("%0t: short_press_mask expected %b actual %b",
                         $realtime, exp_rep.shorts, got.shorts);
                errors++;
            end
            if (got.longs !== exp_rep.longs) begin
                $display("%0t: long_hold_mask expected %b actual %b",
                         $realtime, exp_rep.longs, got.longs);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // Clock, reset and block inputs, all known from time zero
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_idx              cfg_idx   = CFG_PLATE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic [SAMPLE_W-1:0]   x_s = '0, y_s = '0, z1_s = '0, z2_s = '0;
    logic                  out_stall = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  contact;
    logic [NUM_KEYS-1:0]   held_mask;
    logic [NUM_KEYS-1:0]   short_mask;
    logic [LONG_W-1:0]     long_mask;

    key_scoreboard sb;
    int n_taken = 0;

    touch_key_decode_debounce i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_x_sample         (x_s),
        .i_y_sample         (y_s),
        .i_z1_sample        (z1_s),
        .i_z2_sample        (z2_s),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_contact          (contact),
        .o_held_mask        (held_mask),
        .o_short_press_mask (short_mask),
        .o_long_hold_mask   (long_mask)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both sides run without gaps over this stretch of items
    function automatic bit quiet_stretch();
        return n_taken >= 300 && n_taken < 380;
    endfunction

    // Upper byte as given, low nibble random
    function automatic logic [SAMPLE_W-1:0] widen(logic [CODE_W-1:0] c);
        return {c, 4'($urandom_range(0, 15))};
    endfunction

    // Random code in a window, edges favoured
    function automatic logic [CODE_W-1:0] pick_code(logic [CODE_W-1:0] lo,
                                                    logic [CODE_W-1:0] hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return CODE_W'($urandom_range(lo, hi));
    endfunction

    // Offer one item at the falling edge, note it once accepted
    task automatic send(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                        input logic [SAMPLE_W-1:0] z1s, input logic [SAMPLE_W-1:0] z2s);
        while (!quiet_stretch() && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        x_s  <= xs;
        y_s  <= ys;
        z1_s <= z1s;
        z2_s <= z2s;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sb.note_sample(xs, ys, z1s, z2s);
        n_taken++;
        @(negedge i_clk);
    endtask

    // Touch on key k; mostly a sure contact (z2 not above z1)
    task automatic press_key(input int k);
        logic [CODE_W-1:0] xlo, xhi, ylo, yhi, z1c, z2c;
        if (k == 0 || k == 1)      begin xlo = X_C0_MIN; xhi = X_C0_MAX; end
        else if (k == 2 || k == 5) begin xlo = X_C1_MIN; xhi = X_C1_MAX; end
        else                       begin xlo = X_C2_MIN; xhi = X_C2_MAX; end
        if (k == 0 || k == 3 || k == 5) begin ylo = Y_LO_MIN; yhi = Y_LO_MAX; end
        else                            begin ylo = Y_HI_MIN; yhi = Y_HI_MAX; end
        z1c = CODE_W'($urandom_range(1, 255));
        if ($urandom_range(0, 4) == 0) z2c = CODE_W'($urandom_range(0, 255));
        else                           z2c = CODE_W'($urandom_range(0, z1c));
        send(widen(pick_code(xlo, xhi)), widen(pick_code(ylo, yhi)), widen(z1c), widen(z2c));
    endtask

    // Touched, but outside every key window
    task automatic touch_outside();
        logic [CODE_W-1:0] z1c;
        z1c = CODE_W'($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 0)
            send(widen(CODE_W'($urandom_range(0, X_C0_MIN - 1))), 12'($urandom),
                 widen(z1c), widen(CODE_W'($urandom_range(0, z1c))));
        else
            send(widen(pick_code(X_C1_MIN, X_C1_MAX)),
                 widen(CODE_W'($urandom_range(Y_HI_MAX + 1, 255))),
                 widen(z1c), widen(CODE_W'($urandom_range(0, z1c))));
    endtask

    // No contact: Z1 reads zero
    task automatic lift();
        send(12'($urandom), 12'($urandom), widen('0), 12'($urandom));
    endtask

    task automatic noise();
        send(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    // A press with random length and content, or a short run of noise
    task automatic random_burst();
        int k, len, r;
        if ($urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, NUM_KEYS - 1);
            if ($urandom_range(0, 3) == 0) len = $urandom_range(20, 40);
            else                           len = $urandom_range(1, 12);
            for (int j = 0; j < len; j++) begin
                r = $urandom_range(0, 19);
                if (r == 0) k = $urandom_range(0, NUM_KEYS - 1);  // slide
                if (r == 1)      noise();
                else if (r == 2) touch_outside();
                else             press_key(k);
            end
            repeat ($urandom_range(1, 3)) lift();
        end else begin
            repeat ($urandom_range(1, 4)) noise();
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= v;
        @(negedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic apply_settings(input logic [OHMS_W-1:0] p, input logic [OHMS_W-1:0] l,
                                  input logic [TICKS_W-1:0] mn, input logic [TICKS_W-1:0] lg);
        write_reg(CFG_PLATE, CFG_DATA_W'(p));
        write_reg(CFG_LIMIT, CFG_DATA_W'(l));
        write_reg(CFG_MIN, CFG_DATA_W'(mn));
        write_reg(CFG_LONG, CFG_DATA_W'(lg));
        cfg_we <= 1'b0;
    endtask

    // Let every pending report out, then give the block time to settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 3) @(negedge i_clk);
    endtask

    // Result side: compare every accepted report
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            sb.check_report({contact, held_mask, short_mask, long_mask});
    end

    // Receiver stalls: random, one long hold-off, quiet stretch
    initial begin : receiver
        int  hold_left = 0;
        bit  held_off  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!held_off && n_taken >= 150) begin
                held_off  = 1'b1;
                hold_left = 299;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !quiet_stretch() && ($urandom_range(0, 99) < 10);
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin : stimulus
        int target;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset settings
        send(12'hFFF, 12'hFFF, 12'h00F, 12'hFFF);   // Z1 zero: no contact, fields at top
        send(12'h000, 12'h000, 12'hFFF, 12'hFFF);   // touched, no window
        send(12'hFF0, 12'h300, 12'h010, 12'hFF0);   // high resistance: no contact
        send(12'h500, 12'h280, 12'h800, 12'h100);   // z2 below z1: touched, key 0
        repeat (4) press_key(0);
        lift();                                     // short pulse on key 0
        press_key(1);
        lift();                                     // too short: no pulse
        repeat (2) press_key(2);
        repeat (3) press_key(4);                    // slide: keys 2 and 4 both held
        touch_outside();                            // held bits stay
        lift();
        send(12'h3F8, 12'h200, 12'h800, 12'h400);   // just left of the first column
        send(12'hC0F, 12'h59F, 12'h800, 12'h400);   // far window corner: key 4
        send(12'hA20, 12'h400, 12'h800, 12'h400);   // near window corner: key 4 stays
        lift();

        // Random part over several register settings
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: apply_settings(10'd0, 10'd0, 5'd0, 5'd0);
                1: apply_settings(10'd1023, 10'd1023, 5'd31, 5'd31);
                2: apply_settings(10'd1023, 10'd0, 5'd0, 5'd31);
                3: apply_settings(10'd0, 10'd1023, 5'd31, 5'd0);
                4: apply_settings(10'($urandom), 10'($urandom_range(0, 80)),
                                  5'($urandom_range(0, 8)), 5'($urandom_range(0, 20)));
                default: apply_settings(PLATE_RST, LIMIT_RST, MIN_RST, LONG_RST);
            endcase
            target = n_taken + PHASE_ITEMS;
            while (n_taken < target) random_burst();
        end

        // Wind down
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
